### src/mm4_pkg.sv
// Shared types and constants for the 4x4 matrix multiplier.
`default_nettype none

package mm4_pkg;

    localparam int IDX_W       = 4;
    localparam int ELEM_W      = 32;
    localparam int ROW_W       = 2;
    localparam int FRAC_BITS   = 16;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [ELEM_W-1:0] ELEM_MAX = 32'h7FFF_FFFF;
    localparam logic [ELEM_W-1:0] ELEM_MIN = 32'h8000_0000;

    // one load command, classified by the front
    typedef struct packed {
        logic              wr;
        logic              trig;
        logic [IDX_W-1:0]  idx;
        logic [ELEM_W-1:0] left;
        logic [ELEM_W-1:0] right;
    } cmd_t;

    // queue status toward the front
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage

`default_nettype wire

### src/mm4_in_if.sv
// Load channel interface: element pair in.
`default_nettype none

interface mm4_in_if
    import mm4_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [IDX_W-1:0]         elem_index;
    logic signed [ELEM_W-1:0] left_elem;
    logic signed [ELEM_W-1:0] right_elem;
    logic                     load_last;

    modport source (
        output valid, elem_index, left_elem, right_elem, load_last,
        input  ready
    );

    modport sink (
        input  valid, elem_index, left_elem, right_elem, load_last,
        output ready
    );
endinterface

`default_nettype wire

### src/mm4_out_if.sv
// Result channel interface: product element out.
`default_nettype none

interface mm4_out_if
    import mm4_pkg::*;
;
    logic                     valid;
    logic                     ready;
    logic [ROW_W-1:0]         out_row;
    logic [ROW_W-1:0]         out_col;
    logic signed [ELEM_W-1:0] product_elem;
    logic                     result_last;

    modport source (
        output valid, out_row, out_col, product_elem, result_last,
        input  ready
    );

    modport sink (
        input  valid, out_row, out_col, product_elem, result_last,
        output ready
    );
endinterface

`default_nettype wire

### src/mm4_front.sv
// Front end: registers and classifies load items, pushes commands to the queue.
`default_nettype none

module mm4_front
    import mm4_pkg::*;
#(
    parameter int DIM = 4
)
(
    input  logic          clk,
    input  logic          rst_n,
    mm4_in_if.sink        loads,
    input  q_stat_t       q_stat,
    output cmd_t          push_cmd,
    output logic          push_vld
);

    localparam int ELEMS = DIM * DIM;

    logic stage_vld_reg;
    cmd_t stage_cmd_reg;
    cmd_t cmd_next;
    logic take;

    assign loads.ready = !stage_vld_reg || !q_stat.full;
    assign take        = loads.valid && loads.ready;

    always_comb
    begin
        cmd_next.wr    = int'(loads.elem_index) < ELEMS;
        cmd_next.trig  = loads.load_last;
        cmd_next.idx   = loads.elem_index;
        cmd_next.left  = loads.left_elem;
        cmd_next.right = loads.right_elem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_vld_reg <= 1'b0;
        end
        else if (take)
        begin
            stage_vld_reg <= 1'b1;
        end
        else if (!q_stat.full)
        begin
            stage_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            stage_cmd_reg <= cmd_next;
        end
    end

    assign push_cmd = stage_cmd_reg;
    assign push_vld = stage_vld_reg;

endmodule

`default_nettype wire

### src/mm4_cmd_queue.sv
// Command queue between front and back.
`default_nettype none

module mm4_cmd_queue
    import mm4_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cmd_t    push_cmd,
    input  logic    push_vld,
    output q_stat_t q_stat,
    output cmd_t    pop_cmd,
    output logic    pop_vld,
    input  logic    pop
);

    localparam int QPW = $clog2(QUEUE_DEPTH);
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    cmd_t           mem [QUEUE_DEPTH];
    logic [QPW-1:0] wr_ptr_reg;
    logic [QPW-1:0] rd_ptr_reg;
    logic [QCW-1:0] cnt_reg;
    logic           do_push;
    logic           do_pop;

    assign q_stat.full  = cnt_reg == QCW'(QUEUE_DEPTH);
    assign q_stat.empty = cnt_reg == '0;
    assign do_push      = push_vld && !q_stat.full;
    assign do_pop       = pop && !q_stat.empty;
    assign pop_vld      = !q_stat.empty;
    assign pop_cmd      = mem[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

### src/mm4_back.sv
// Back end: element stores, multiply-accumulate pipeline and result register.
`default_nettype none

module mm4_back
    import mm4_pkg::*;
#(
    parameter int DIM = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  logic      cmd_vld,
    output logic      cmd_pop,
    mm4_out_if.source results
);

    localparam int ELEMS = DIM * DIM;
    localparam int IW    = $clog2(ELEMS);
    localparam int DW    = $clog2(DIM);
    localparam int PW    = 2 * ELEM_W;
    localparam int AW    = PW + $clog2(DIM);
    localparam int SW    = AW - FRAC_BITS;

    localparam logic [IW-1:0] DIM_I = IW'(DIM);
    localparam logic [DW-1:0] LAST  = DW'(DIM - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_WAIT
    } state_t;

    state_t state_reg;
    logic [DW-1:0] row_reg;
    logic [DW-1:0] col_reg;
    logic [DW-1:0] k_reg;

    // element stores
    logic [ELEM_W-1:0] left_mem  [ELEMS];
    logic [ELEM_W-1:0] right_mem [ELEMS];
    logic [ELEMS-1:0]  written_reg;
    logic              wr_en;
    logic [IW-1:0]     wr_addr;
    logic [IW-1:0]     a_addr;
    logic [IW-1:0]     b_addr;

    // pipeline
    logic                     issue;
    logic [ELEM_W-1:0]        a_rd_reg;
    logic [ELEM_W-1:0]        b_rd_reg;
    logic                     a_ok_reg;
    logic                     b_ok_reg;
    logic                     s1_vld_reg;
    logic                     s1_first_reg;
    logic                     s1_lastk_reg;
    logic signed [ELEM_W-1:0] a_op;
    logic signed [ELEM_W-1:0] b_op;
    logic signed [PW-1:0]     prod_next;
    logic signed [PW-1:0]     prod_reg;
    logic                     s2_vld_reg;
    logic                     s2_first_reg;
    logic                     s2_lastk_reg;
    logic signed [AW-1:0]     acc_reg;
    logic signed [AW-1:0]     acc_next;
    logic                     done_reg;

    // result
    logic signed [SW-1:0]   shifted;
    logic [SW-ELEM_W:0]     hi_bits;
    logic [ELEM_W-1:0]      sat;
    logic                   out_free;
    logic                   load_out;
    logic                   final_elem;

    logic                   out_vld_reg;
    logic [ROW_W-1:0]       out_row_reg;
    logic [ROW_W-1:0]       out_col_reg;
    logic [ELEM_W-1:0]      out_prod_reg;
    logic                   out_last_reg;

    assign cmd_pop = (state_reg == ST_IDLE) && cmd_vld;
    assign wr_en   = cmd_pop && cmd.wr;
    assign wr_addr = IW'(cmd.idx);
    assign a_addr  = row_reg * DIM_I + IW'(k_reg);
    assign b_addr  = IW'(k_reg) * DIM_I + IW'(col_reg);
    assign issue   = state_reg == ST_ISSUE;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            left_mem[wr_addr]  <= cmd.left;
            right_mem[wr_addr] <= cmd.right;
        end
        a_rd_reg <= left_mem[a_addr];
        b_rd_reg <= right_mem[b_addr];
    end

    // unwritten entries read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            a_ok_reg    <= 1'b0;
            b_ok_reg    <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            a_ok_reg <= written_reg[a_addr];
            b_ok_reg <= written_reg[b_addr];
        end
    end

    assign a_op      = a_ok_reg ? $signed(a_rd_reg) : '0;
    assign b_op      = b_ok_reg ? $signed(b_rd_reg) : '0;
    assign prod_next = a_op * b_op;
    assign acc_next  = s2_first_reg ? AW'(prod_reg) : acc_reg + AW'(prod_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg   <= 1'b0;
            s1_first_reg <= 1'b0;
            s1_lastk_reg <= 1'b0;
            s2_vld_reg   <= 1'b0;
            s2_first_reg <= 1'b0;
            s2_lastk_reg <= 1'b0;
            done_reg     <= 1'b0;
        end
        else
        begin
            s1_vld_reg   <= issue;
            s1_first_reg <= k_reg == '0;
            s1_lastk_reg <= k_reg == LAST;
            s2_vld_reg   <= s1_vld_reg;
            s2_first_reg <= s1_first_reg;
            s2_lastk_reg <= s1_lastk_reg;
            if (s2_vld_reg && s2_lastk_reg)
            begin
                done_reg <= 1'b1;
            end
            else if (load_out)
            begin
                done_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_vld_reg)
        begin
            prod_reg <= prod_next;
        end
        if (s2_vld_reg)
        begin
            acc_reg <= acc_next;
        end
    end

    // floor shift, then saturate to 32 bits
    assign shifted = SW'(acc_reg >>> FRAC_BITS);
    assign hi_bits = shifted[SW-1:ELEM_W-1];

    always_comb
    begin
        if (hi_bits == '0 || hi_bits == '1)
        begin
            sat = shifted[ELEM_W-1:0];
        end
        else
        begin
            sat = shifted[SW-1] ? ELEM_MIN : ELEM_MAX;
        end
    end

    assign out_free   = !out_vld_reg || results.ready;
    assign load_out   = (state_reg == ST_WAIT) && done_reg && out_free;
    assign final_elem = (row_reg == LAST) && (col_reg == LAST);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            row_reg      <= '0;
            col_reg      <= '0;
            k_reg        <= '0;
            out_vld_reg  <= 1'b0;
            out_row_reg  <= '0;
            out_col_reg  <= '0;
            out_prod_reg <= '0;
            out_last_reg <= 1'b0;
        end
        else
        begin
            if (load_out)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (results.ready)
            begin
                out_vld_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (cmd_vld && cmd.trig)
                    begin
                        row_reg   <= '0;
                        col_reg   <= '0;
                        k_reg     <= '0;
                        state_reg <= ST_ISSUE;
                    end
                end
                ST_ISSUE:
                begin
                    if (k_reg == LAST)
                    begin
                        k_reg     <= '0;
                        state_reg <= ST_WAIT;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                ST_WAIT:
                begin
                    if (load_out)
                    begin
                        out_row_reg  <= ROW_W'(row_reg);
                        out_col_reg  <= ROW_W'(col_reg);
                        out_prod_reg <= sat;
                        out_last_reg <= final_elem;
                        if (final_elem)
                        begin
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            state_reg <= ST_ISSUE;
                            if (col_reg == LAST)
                            begin
                                col_reg <= '0;
                                row_reg <= row_reg + 1'b1;
                            end
                            else
                            begin
                                col_reg <= col_reg + 1'b1;
                            end
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign results.valid        = out_vld_reg;
    assign results.out_row      = out_row_reg;
    assign results.out_col      = out_col_reg;
    assign results.product_elem = out_prod_reg;
    assign results.result_last  = out_last_reg;

endmodule

`default_nettype wire

### src/matrix4x4_multiply.sv
// Usage:
//   Matrix multiplier C = A x B on signed Q16.16 elements, DIM x DIM (default 4).
//   loads:   one item writes A[idx] and B[idx] at a row-major index; indexes
//            beyond the matrix are not written. An item with load_last set
//            writes first and then starts the multiply.
//   results: DIM*DIM product elements in row-major order, result_last on the
//            final one. Each is the exact sum of the full products, shifted
//            right by 16 (floor) and saturated to 32 bits.
//   Loads are taken one per cycle while the queue has room, into a four-entry
//   command queue; the front keeps accepting while the back multiplies or a
//   result waits, until the queue fills. A load passes the front register and
//   the queue to the stores; the back pops only while idle. A multiply starts
//   as the trigger leaves the queue. Each product element walks the single
//   32x32 multiplier over the inner sum through its read, multiply and
//   accumulate stages; the next is issued once the result register takes it.
//   Reset: both stores read as zero, the queue and the result register empty.
//   A stalled receiver holds the result register and stops the multiply; the
//   queue then fills and loads.ready drops.
`default_nettype none

module matrix4x4_multiply
    import mm4_pkg::*;
#(
    parameter int DIM = 4
)
(
    input  logic      clk,
    input  logic      rst_n,
    mm4_in_if.sink    loads,
    mm4_out_if.source results
);

    cmd_t    push_cmd;
    logic    push_vld;
    q_stat_t q_stat;
    cmd_t    pop_cmd;
    logic    pop_vld;
    logic    pop;

    mm4_front #(
        .DIM (DIM)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .loads    (loads),
        .q_stat   (q_stat),
        .push_cmd (push_cmd),
        .push_vld (push_vld)
    );

    mm4_cmd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push_cmd (push_cmd),
        .push_vld (push_vld),
        .q_stat   (q_stat),
        .pop_cmd  (pop_cmd),
        .pop_vld  (pop_vld),
        .pop      (pop)
    );

    mm4_back #(
        .DIM (DIM)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (pop_cmd),
        .cmd_vld (pop_vld),
        .cmd_pop (pop),
        .results (results)
    );

endmodule

`default_nettype wire

### src/mm4_checker.sv
// Port-level checks for the matrix multiplier, bound to the top level.
`default_nettype none

module mm4_checker
    import mm4_pkg::*;
#(
    parameter int DIM = 4
)
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [ROW_W-1:0]         out_row,
    input logic [ROW_W-1:0]         out_col,
    input logic signed [ELEM_W-1:0] product_elem,
    input logic                     result_last
);

    localparam logic [ROW_W-1:0] LAST_POS = ROW_W'(DIM - 1);

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(product_elem)
            && $stable(out_row) && $stable(out_col) && $stable(result_last))
        else $error("result item changed while stalled");

    a_reset: assert property (@(posedge clk)
        !rst_n |=> !out_valid)
        else $error("result valid during reset");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && result_last |-> out_row == LAST_POS && out_col == LAST_POS)
        else $error("last flag away from the final element");

endmodule

bind matrix4x4_multiply mm4_checker #(
    .DIM (DIM)
) u_mm4_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_row      (results.out_row),
    .out_col      (results.out_col),
    .product_elem (results.product_elem),
    .result_last  (results.result_last)
);

`default_nettype wire

### dv/testbench.sv
// Testbench for matrix4x4_multiply: random and directed loads, predicted products checked.
module testbench
    import mm4_pkg::*;
;

    localparam int DIM        = 4;
    localparam int N_ELEMS    = DIM * DIM;
    localparam int RAND_ITEMS = 260;
    localparam int QUIET_MAX  = 2000;
    localparam int TAIL_WAIT  = 200;

    typedef enum int { VAL_SMALL, VAL_FULL, VAL_EDGE } val_kind_e;

    typedef struct {
        logic [IDX_W-1:0]         idx;
        logic signed [ELEM_W-1:0] left;
        logic signed [ELEM_W-1:0] right;
        logic                     last;
        bit                       drain_first;
    } load_item_t;

    typedef struct {
        logic [ROW_W-1:0]         row;
        logic [ROW_W-1:0]         col;
        logic signed [ELEM_W-1:0] elem;
        logic                     last;
    } product_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    mm4_in_if  loads_if ();
    mm4_out_if results_if ();

    matrix4x4_multiply u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .loads   (loads_if),
        .results (results_if)
    );

    always #4 clk = ~clk;

    load_item_t               load_queue[$];
    product_t                 pending_products[$];
    logic signed [ELEM_W-1:0] left_mat[N_ELEMS];
    logic signed [ELEM_W-1:0] right_mat[N_ELEMS];
    int                       owed_count;
    int                       errors;
    int unsigned              cycle_count;
    int                       quiet_cycles;
    logic                     gap_free;

    assign gap_free = cycle_count >= 1500 && cycle_count < 3000;

    function automatic logic signed [ELEM_W-1:0] dot_product(int r, int c);
        logic signed [2*ELEM_W+1:0] acc;
        logic signed [2*ELEM_W+1:0] scaled;
        acc = '0;
        for (int k = 0; k < DIM; k++)
        begin
            acc = acc + left_mat[r*DIM + k] * right_mat[k*DIM + c];
        end
        scaled = acc >>> FRAC_BITS;
        if (scaled > $signed(ELEM_MAX))
            return ELEM_MAX;
        if (scaled < $signed(ELEM_MIN))
            return ELEM_MIN;
        return scaled[ELEM_W-1:0];
    endfunction

    task automatic apply_load();
        product_t p;
        int n;
        if (loads_if.elem_index < N_ELEMS)
        begin
            left_mat[loads_if.elem_index]  = loads_if.left_elem;
            right_mat[loads_if.elem_index] = loads_if.right_elem;
        end
        if (loads_if.load_last)
        begin
            n = 0;
            for (int r = 0; r < DIM; r++)
            begin
                for (int c = 0; c < DIM; c++)
                begin
                    p.row  = r[ROW_W-1:0];
                    p.col  = c[ROW_W-1:0];
                    p.elem = dot_product(r, c);
                    p.last = (n == N_ELEMS - 1);
                    pending_products.push_back(p);
                    n++;
                end
            end
        end
    endtask

    task automatic check_product();
        product_t want;
        if (pending_products.size() == 0)
        begin
            $error("product item with none expected: row %0d col %0d value %0d",
                   results_if.out_row, results_if.out_col, results_if.product_elem);
            errors++;
            return;
        end
        want = pending_products.pop_front();
        if (results_if.out_row !== want.row)
        begin
            $error("out_row expected %0d got %0d", want.row, results_if.out_row);
            errors++;
        end
        if (results_if.out_col !== want.col)
        begin
            $error("out_col expected %0d got %0d", want.col, results_if.out_col);
            errors++;
        end
        if (results_if.product_elem !== want.elem)
        begin
            $error("product_elem expected %0d got %0d", want.elem, results_if.product_elem);
            errors++;
        end
        if (results_if.result_last !== want.last)
        begin
            $error("result_last expected %0d got %0d", want.last, results_if.result_last);
            errors++;
        end
    endtask

    // load driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            loads_if.valid <= 1'b0;
        end
        else if (!loads_if.valid || loads_if.ready)
        begin
            if (load_queue.size() == 0
                || (load_queue[0].drain_first && (loads_if.valid || owed_count != 0))
                || (!gap_free && $urandom_range(99) < 15))
            begin
                loads_if.valid <= 1'b0;
            end
            else
            begin
                load_item_t it;
                it = load_queue.pop_front();
                loads_if.valid      <= 1'b1;
                loads_if.elem_index <= it.idx;
                loads_if.left_elem  <= it.left;
                loads_if.right_elem <= it.right;
                loads_if.load_last  <= it.last;
            end
        end
    end

    // result sink
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            results_if.ready <= 1'b0;
        else
            results_if.ready <= gap_free || $urandom_range(99) >= 15;
    end

    // monitor and predictor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            owed_count <= 0;
            for (int i = 0; i < N_ELEMS; i++)
            begin
                left_mat[i]  = '0;
                right_mat[i] = '0;
            end
        end
        else
        begin
            if (loads_if.valid && loads_if.ready)
                apply_load();
            if (results_if.valid && results_if.ready)
                check_product();
            owed_count <= pending_products.size();
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (rst_n && !(loads_if.valid && loads_if.ready)
            && !(results_if.valid && results_if.ready))
            quiet_cycles <= quiet_cycles + 1;
        else
            quiet_cycles <= 0;
        if (quiet_cycles == QUIET_MAX)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    function automatic logic signed [ELEM_W-1:0] pick_elem(val_kind_e kind);
        logic signed [ELEM_W-1:0] v;
        case (kind)
            VAL_FULL:
                v = $urandom;
            VAL_EDGE:
                case ($urandom_range(5))
                    0: v = ELEM_MAX;
                    1: v = ELEM_MIN;
                    2: v = '0;
                    3: v = -1;
                    4: v = 32'sh0001_0000;
                    default: v = -32'sh0001_0000;
                endcase
            default:
            begin
                // roughly -8.0 .. 8.0
                v = $urandom_range(0, 32'h000F_FFFF);
                v = v - 32'sh0008_0000;
            end
        endcase
        return v;
    endfunction

    function automatic load_item_t make_load(int idx, logic signed [ELEM_W-1:0] a,
                                             logic signed [ELEM_W-1:0] b, logic last);
        load_item_t it;
        it.idx         = idx[IDX_W-1:0];
        it.left        = a;
        it.right       = b;
        it.last        = last;
        it.drain_first = 1'b0;
        return it;
    endfunction

    function automatic val_kind_e pick_kind();
        int roll;
        roll = $urandom_range(99);
        if (roll < 60)
            return VAL_SMALL;
        if (roll < 85)
            return VAL_FULL;
        return VAL_EDGE;
    endfunction

    initial
    begin
        int         added;
        int         seq_no;
        int         perm[N_ELEMS];
        int         n;
        int         j;
        int         tmp;
        int         roll;
        val_kind_e  kind;
        load_item_t it;

        loads_if.valid      = 1'b0;
        loads_if.elem_index = '0;
        loads_if.left_elem  = '0;
        loads_if.right_elem = '0;
        loads_if.load_last  = 1'b0;
        results_if.ready    = 1'b0;
        errors              = 0;
        cycle_count         = 0;
        quiet_cycles        = 0;

        // multiply with most elements never written
        load_queue.push_back(make_load(5, ELEM_MAX, ELEM_MIN, 1'b1));
        // saturation both ways, min * min, floor of a negative fraction
        load_queue.push_back(make_load(0, ELEM_MAX, ELEM_MAX, 1'b1));
        load_queue.push_back(make_load(0, ELEM_MIN, ELEM_MAX, 1'b1));
        load_queue.push_back(make_load(0, ELEM_MIN, ELEM_MIN, 1'b1));
        load_queue.push_back(make_load(0, 1, -1, 1'b1));
        // loads without last, then a trigger
        load_queue.push_back(make_load(3, 32'sh0001_0000, -32'sh0001_0000, 1'b0));
        load_queue.push_back(make_load(12, 32'sh7FFF_0000, 32'sh0000_8000, 1'b0));
        load_queue.push_back(make_load(10, -1, ELEM_MAX, 1'b0));
        load_queue.push_back(make_load(15, -1, -1, 1'b1));
        load_queue.push_back(make_load(15, ELEM_MAX, ELEM_MIN, 1'b0));
        load_queue.push_back(make_load(6, 32'sh0002_8000, 32'sh0000_4000, 1'b1));
        // negative saturation across a full row
        for (int k = 0; k < DIM; k++)
            load_queue.push_back(make_load(k*DIM + 1, ELEM_MIN, ELEM_MAX, 1'b0));
        for (int k = 0; k < DIM; k++)
            load_queue.push_back(make_load(DIM + k, ELEM_MAX, ELEM_MAX, k == DIM - 1));

        added  = 0;
        seq_no = 0;
        while (added < RAND_ITEMS)
        begin
            roll = $urandom_range(99);
            kind = pick_kind();
            if (roll < 65)
            begin
                for (int i = 0; i < N_ELEMS; i++)
                    perm[i] = i;
                for (int i = N_ELEMS - 1; i > 0; i--)
                begin
                    j       = $urandom_range(i);
                    tmp     = perm[i];
                    perm[i] = perm[j];
                    perm[j] = tmp;
                end
                for (int i = 0; i < N_ELEMS; i++)
                begin
                    it = make_load(perm[i], pick_elem(kind), pick_elem(kind),
                                   i == N_ELEMS - 1);
                    if (seq_no == 8 && i == 0)
                        it.drain_first = 1'b1;
                    load_queue.push_back(it);
                end
                added += N_ELEMS;
            end
            else
            begin
                n = (roll < 90) ? $urandom_range(1, 6) : $urandom_range(1, 4);
                for (int i = 0; i < n; i++)
                begin
                    it = make_load($urandom_range(N_ELEMS - 1), pick_elem(kind),
                                   pick_elem(kind), roll < 90 && i == n - 1);
                    if (seq_no == 8 && i == 0)
                        it.drain_first = 1'b1;
                    load_queue.push_back(it);
                end
                added += n;
            end
            seq_no++;
        end

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        while (load_queue.size() != 0 || loads_if.valid)
            @(posedge clk);
        @(posedge clk);
        while (owed_count != 0)
            @(posedge clk);
        repeat (TAIL_WAIT) @(posedge clk);

        if (errors == 0 && pending_products.size() == 0)
        begin
            $display("testbench OK");
        end
        else
        begin
            $error("%0d product items never arrived", pending_products.size());
            $display("testbench NOT OK");
        end
        $finish;
    end

endmodule
